@@ design/heart_beat_rate_detector_assert.svh @@
`ifndef HEART_BEAT_RATE_DETECTOR_ASSERT_SVH
`define HEART_BEAT_RATE_DETECTOR_ASSERT_SVH

// a in one cycle implies b in the same cycle
`define HRD_ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("implication check failed");

// a in one cycle implies b in the next cycle
`define HRD_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("next-cycle check failed");

// a never holds
`define HRD_ASSERT_NEVER(label, clk, rst_n, a) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(a)) \
        else $error("forbidden condition seen");

`endif

@@ design/hrd_pkg.sv @@
package hrd_pkg;

    localparam int P_TIME_BITS   = 48;
    localparam int P_SAMPLE_BITS = 12;

    localparam int THR_BITS    = 12;
    localparam int DIV_BITS    = 20;
    localparam int QUO_BITS    = 16;
    localparam int STEP_BITS   = $clog2(QUO_BITS);

    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [CFG_INDEX_BITS-1:0] REG_UPPER_THR = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOWER_THR = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] REG_CYC_PER_MS = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] REG_PERIOD_LIM = CFG_INDEX_BITS'(3);

    localparam logic [THR_BITS-1:0] UPPER_THR_RST  = THR_BITS'(1985);
    localparam logic [THR_BITS-1:0] LOWER_THR_RST  = THR_BITS'(1737);
    localparam logic [DIV_BITS-1:0] CYC_PER_MS_RST = DIV_BITS'(48000);
    localparam logic [QUO_BITS-1:0] PERIOD_LIM_RST = QUO_BITS'(10000);
    localparam logic [QUO_BITS-1:0] MS_PER_MINUTE  = QUO_BITS'(60000);
    localparam logic [QUO_BITS-1:0] PERIOD_MAX     = '1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RANGE,
        S_DIV_MS,
        S_BPM_START,
        S_DIV_BPM,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                start;
        logic [DIV_BITS-1:0] rem_init;
        logic [QUO_BITS-1:0] dividend_lo;
        logic [DIV_BITS-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [QUO_BITS-1:0] quotient;
    } t_div_rsp;

endpackage

@@ design/hrd_if.sv @@
interface hrd_in_if import hrd_pkg::*; #(
    parameter int SAMPLE_BITS = P_SAMPLE_BITS,
    parameter int TIME_BITS   = P_TIME_BITS
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic [TIME_BITS-1:0]   time_cycles;

    modport source (output valid, sample, time_cycles, input ready);
    modport sink   (input valid, sample, time_cycles, output ready);
endinterface

interface hrd_out_if import hrd_pkg::*;;
    logic                valid;
    logic                ready;
    logic                beat_seen;
    logic                level_high;
    logic [QUO_BITS-1:0] beat_interval;
    logic [QUO_BITS-1:0] beats_per_minute;
    logic                rate_valid;

    modport source (output valid, beat_seen, level_high, beat_interval, beats_per_minute,
                    rate_valid, input ready);
    modport sink   (input valid, beat_seen, level_high, beat_interval, beats_per_minute,
                    rate_valid, output ready);
endinterface

interface hrd_cfg_if import hrd_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ design/heart_beat_rate_detector.sv @@
// Pulse-rate meter with Schmitt-trigger beat detection.
// i_in carries one sensor sample and its cycle timestamp per request; o_out
// returns exactly one result per sample: beat flag, trigger level and the
// held period (ms), beats per minute and validity. i_cfg writes the four
// registers (thresholds, cycles per ms, period limit) and is always ready;
// write it only while the block is idle.
// A sample that is not a beat edge passes from idle through the done state
// to the output register. A beat edge runs the shared 16-step restoring
// divider twice, once for cycles to ms and once for 60000 / ms, through the
// range, first divide, rate start, second divide and done states; a saturated
// period skips the first division and a zero period skips the second.
// One sample is in work at a time: i_in.ready is high only when the block is
// idle and the output register is empty, so the block takes no new sample
// until it is through with the last one.
// A stalled receiver holds the result in the output register and the block
// takes no new sample until it is taken.
// Reset clears the trigger, the last edge time and the held values, and
// loads the register defaults.
module heart_beat_rate_detector import hrd_pkg::*; #(
    parameter int TIME_BITS   = P_TIME_BITS,
    parameter int SAMPLE_BITS = P_SAMPLE_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hrd_in_if.sink     i_in,
    hrd_out_if.source  o_out,
    hrd_cfg_if.sink    i_cfg
);
    localparam int SCMP_BITS = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;
    localparam int WIDE_BITS = (TIME_BITS > DIV_BITS + QUO_BITS) ? TIME_BITS
                                                                 : DIV_BITS + QUO_BITS;

    t_state r_state, n_state;

    logic [THR_BITS-1:0]  r_upper_thr;
    logic [THR_BITS-1:0]  r_lower_thr;
    logic [DIV_BITS-1:0]  r_cyc_per_ms;
    logic [QUO_BITS-1:0]  r_period_lim;

    logic                 r_above;
    logic [TIME_BITS-1:0] r_last;
    logic [QUO_BITS-1:0]  r_period;
    logic [QUO_BITS-1:0]  r_rate;
    logic                 r_valid;
    logic                 r_beat;
    logic [TIME_BITS-1:0] r_cycles;

    logic                 r_out_valid;
    logic                 r_out_beat;
    logic                 r_out_level;
    logic [QUO_BITS-1:0]  r_out_period;
    logic [QUO_BITS-1:0]  r_out_rate;
    logic                 r_out_rvalid;

    logic                 in_take;
    logic                 is_beat;
    logic                 is_low;
    logic [SCMP_BITS-1:0] smp_ext;
    logic [DIV_BITS-1:0]  eff_div;
    logic [WIDE_BITS-1:0] cyc_ext;
    logic [WIDE_BITS-1:0] sat_lim;
    logic                 saturate;
    t_div_req             div_req;
    t_div_rsp             div_rsp;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE) && !r_out_valid;
    assign in_take     = i_in.valid && i_in.ready;

    always_comb begin
        smp_ext  = SCMP_BITS'(i_in.sample);
        is_beat  = (smp_ext > SCMP_BITS'(r_upper_thr)) && !r_above;
        is_low   = smp_ext < SCMP_BITS'(r_lower_thr);
        eff_div  = (r_cyc_per_ms == '0) ? DIV_BITS'(1) : r_cyc_per_ms;
        cyc_ext  = WIDE_BITS'(r_cycles);
        // quotient would not fit 16 bits
        sat_lim  = WIDE_BITS'({eff_div, {QUO_BITS{1'b0}}});
        saturate = cyc_ext >= sat_lim;
    end

    hrd_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_take) n_state = is_beat ? S_RANGE : S_DONE;
            end
            S_RANGE:     n_state = saturate ? S_BPM_START : S_DIV_MS;
            S_DIV_MS: begin
                if (div_rsp.done) begin
                    n_state = (div_rsp.quotient == '0) ? S_DONE : S_BPM_START;
                end
            end
            S_BPM_START: n_state = S_DIV_BPM;
            S_DIV_BPM: begin
                if (div_rsp.done) n_state = S_DONE;
            end
            S_DONE:      n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // divider requests
    always_comb begin
        div_req = '0;
        unique case (r_state)
            S_RANGE: begin
                div_req.start       = !saturate;
                div_req.rem_init    = cyc_ext[QUO_BITS +: DIV_BITS];
                div_req.dividend_lo = r_cycles[QUO_BITS-1:0];
                div_req.divisor     = eff_div;
            end
            S_BPM_START: begin
                div_req.start       = 1'b1;
                div_req.dividend_lo = MS_PER_MINUTE;
                div_req.divisor     = DIV_BITS'(r_period);
            end
            default: div_req = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_upper_thr  <= UPPER_THR_RST;
            r_lower_thr  <= LOWER_THR_RST;
            r_cyc_per_ms <= CYC_PER_MS_RST;
            r_period_lim <= PERIOD_LIM_RST;
            r_above      <= 1'b0;
            r_last       <= '0;
            r_period     <= '0;
            r_rate       <= '0;
            r_valid      <= 1'b0;
            r_beat       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    REG_UPPER_THR:  r_upper_thr  <= i_cfg.data[THR_BITS-1:0];
                    REG_LOWER_THR:  r_lower_thr  <= i_cfg.data[THR_BITS-1:0];
                    REG_CYC_PER_MS: r_cyc_per_ms <= i_cfg.data[DIV_BITS-1:0];
                    REG_PERIOD_LIM: r_period_lim <= i_cfg.data[QUO_BITS-1:0];
                    default: ;
                endcase
            end

            if (in_take) begin
                r_beat <= is_beat;
                if (is_beat) begin
                    r_last  <= i_in.time_cycles;
                    r_above <= 1'b1;
                end else if (is_low && r_above) begin
                    r_above <= 1'b0;
                end
            end

            unique case (r_state)
                S_RANGE: begin
                    if (saturate) r_period <= PERIOD_MAX;
                end
                S_DIV_MS: begin
                    if (div_rsp.done) begin
                        r_period <= div_rsp.quotient;
                        if (div_rsp.quotient == '0) begin
                            r_rate  <= '0;
                            r_valid <= 1'b0;
                        end
                    end
                end
                S_BPM_START: r_valid <= r_period < r_period_lim;
                S_DIV_BPM: begin
                    if (div_rsp.done) r_rate <= div_rsp.quotient;
                end
                default: ;
            endcase

            if (r_state == S_DONE) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take && is_beat) begin
            r_cycles <= i_in.time_cycles - r_last;
        end
        if (r_state == S_DONE) begin
            r_out_beat   <= r_beat;
            r_out_level  <= r_above;
            r_out_period <= r_period;
            r_out_rate   <= r_rate;
            r_out_rvalid <= r_valid;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.beat_seen        = r_out_beat;
    assign o_out.level_high       = r_out_level;
    assign o_out.beat_interval    = r_out_period;
    assign o_out.beats_per_minute = r_out_rate;
    assign o_out.rate_valid       = r_out_rvalid;

endmodule

@@ design/hrd_divider.sv @@
module hrd_divider import hrd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(QUO_BITS - 1);

    logic                 r_busy;
    logic                 r_done;
    logic [STEP_BITS-1:0] r_cnt;
    logic [DIV_BITS-1:0]  r_rem;
    logic [QUO_BITS-1:0]  r_lo;
    logic [QUO_BITS-1:0]  r_q;
    logic [DIV_BITS-1:0]  r_den;

    logic [DIV_BITS:0]    trial;
    logic [DIV_BITS:0]    diff;
    logic                 take;
    logic [DIV_BITS-1:0]  n_rem;

    // one restoring step: remainder stays below the divisor
    always_comb begin
        trial = {r_rem, r_lo[QUO_BITS-1]};
        diff  = trial - {1'b0, r_den};
        take  = trial >= {1'b0, r_den};
        n_rem = take ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == STEP_LAST) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_cnt <= '0;
            r_rem <= i_req.rem_init;
            r_lo  <= i_req.dividend_lo;
            r_den <= i_req.divisor;
            r_q   <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + STEP_BITS'(1);
            r_rem <= n_rem;
            r_lo  <= {r_lo[QUO_BITS-2:0], 1'b0};
            r_q   <= {r_q[QUO_BITS-2:0], take};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;

endmodule

@@ design/hrd_checker.sv @@
`include "heart_beat_rate_detector_assert.svh"

module hrd_checker import hrd_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic                i_beat_seen,
    input logic                i_level_high,
    input logic [QUO_BITS-1:0] i_beat_interval,
    input logic                i_rate_valid
);
    // a result waiting for the receiver stays offered
    `HRD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // one sample in work at a time
    `HRD_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)
    `HRD_ASSERT_NEVER(a_ready_while_full, i_clk, i_rst_n, i_in_ready && i_out_valid)

    // a beat edge always leaves the trigger high
    `HRD_ASSERT_IMPLIES(a_beat_level, i_clk, i_rst_n, i_out_valid && i_beat_seen,
                        i_level_high)

    // a valid rate has a period that is neither zero nor saturated
    `HRD_ASSERT_IMPLIES(a_valid_period, i_clk, i_rst_n, i_out_valid && i_rate_valid,
                        (i_beat_interval != '0) && (i_beat_interval != PERIOD_MAX))
endmodule

bind heart_beat_rate_detector hrd_checker u_hrd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_beat_seen     (o_out.beat_seen),
    .i_level_high    (o_out.level_high),
    .i_beat_interval (o_out.beat_interval),
    .i_rate_valid    (o_out.rate_valid)
);
